// File: hw/rtl/ccs_pkg.sv
// Shared types and constants for the channel contrast stretch block.
// No dependencies; every other file of the block imports this package.
package ccs_pkg;

  localparam int SAMPLE_W = 16;
  localparam int NUM_W    = 24;
  localparam int DEN_W    = 16;
  localparam int QUO_W    = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;

  localparam logic signed [SAMPLE_W-1:0] STAT_MIN_RST = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] STAT_MAX_RST = 16'sh8000;
  localparam logic [QUO_W-1:0]           BYTE_MAX     = 8'd255;

  typedef enum logic [1:0] {
    MODE_CLEAR   = 2'd0,
    MODE_GATHER  = 2'd1,
    MODE_CONVERT = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENHANCE  = 1'd0,
    CFG_CHANNELS = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]                  mode;
    logic [1:0]                  channel;
    logic signed [SAMPLE_W-1:0]  sample_value;
  } in_item_t;

  typedef struct packed {
    logic [QUO_W-1:0] pixel_byte;
    logic             bad_channel;
  } out_item_t;

  // Command to the min/max store.
  typedef struct packed {
    logic       clr;
    logic       upd;
    logic [1:0] ch;
  } stats_cmd_t;

endpackage

// File: hw/rtl/ccs_if.sv
// Valid/ready channel interfaces for the channel contrast stretch block.
// Depends on ccs_pkg for the item types.
interface ccs_in_if import ccs_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ccs_out_if import ccs_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/ccs_stats.sv
// Per-channel running minimum and maximum store.
// Depends on ccs_pkg; one register pair per channel, read at one address.
module ccs_stats import ccs_pkg::*; #(
  parameter int MAX_CHANNELS = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  stats_cmd_t                 cmd,
  input  logic signed [SAMPLE_W-1:0] upd_val,
  input  logic [1:0]                 rd_ch,
  output logic signed [SAMPLE_W-1:0] rd_min,
  output logic signed [SAMPLE_W-1:0] rd_max
);

  logic signed [SAMPLE_W-1:0] min_r   [MAX_CHANNELS];
  logic signed [SAMPLE_W-1:0] max_r   [MAX_CHANNELS];
  logic signed [SAMPLE_W-1:0] min_nxt [MAX_CHANNELS];
  logic signed [SAMPLE_W-1:0] max_nxt [MAX_CHANNELS];

  always_comb begin
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      min_nxt[i] = min_r[i];
      max_nxt[i] = max_r[i];
      if (cmd.clr) begin
        min_nxt[i] = STAT_MIN_RST;
        max_nxt[i] = STAT_MAX_RST;
      end else if (cmd.upd && (cmd.ch == 2'(i))) begin
        if (upd_val < min_r[i]) min_nxt[i] = upd_val;
        if (upd_val > max_r[i]) max_nxt[i] = upd_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      if (!rst_n) begin
        min_r[i] <= STAT_MIN_RST;
        max_r[i] <= STAT_MAX_RST;
      end else begin
        min_r[i] <= min_nxt[i];
        max_r[i] <= max_nxt[i];
      end
    end
  end

  // Read mux; callers only ask for a channel below MAX_CHANNELS.
  always_comb begin
    rd_min = STAT_MIN_RST;
    rd_max = STAT_MAX_RST;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      if (rd_ch == 2'(i)) begin
        rd_min = min_r[i];
        rd_max = max_r[i];
      end
    end
  end

`ifndef SYNTHESIS
  property p_clear_resets;
    @(posedge clk) disable iff (!rst_n)
      cmd.clr |=> (rd_min == STAT_MIN_RST) && (rd_max == STAT_MAX_RST);
  endproperty
  a_clear_resets: assert property (p_clear_resets)
    else $error("min/max not back at reset values after clear");

  property p_update_orders;
    @(posedge clk) disable iff (!rst_n)
      (cmd.upd && !cmd.clr && (rd_ch == cmd.ch)) |=> (rd_min <= rd_max);
  endproperty
  a_update_orders: assert property (p_update_orders)
    else $error("channel minimum above maximum after gather");

  property p_idle_holds;
    @(posedge clk) disable iff (!rst_n)
      (!cmd.clr && !cmd.upd) |=> $stable(rd_min) || !$stable(rd_ch);
  endproperty
  a_idle_holds: assert property (p_idle_holds)
    else $error("min store changed without a command");
`endif

endmodule

// File: hw/rtl/ccs_div.sv
// Iterative restoring divider: one quotient bit per cycle, saturating at 255.
// Depends on ccs_pkg for widths; divisor must be nonzero.
module ccs_div import ccs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [QUO_W-1:0] quo
);

  localparam logic [3:0] STEP_SAT = 4'(QUO_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [3:0]       step_r, step_nxt;
  logic [NUM_W-1:0] rem_r,  rem_nxt;
  logic [NUM_W-1:0] dsh_r,  dsh_nxt;
  logic [QUO_W-1:0] quo_r,  quo_nxt;
  logic             ge;

  assign ge = (rem_r >= dsh_r);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_SAT;
      rem_nxt  = num;
      dsh_nxt  = {den, {(NUM_W-DEN_W){1'b0}}};
      quo_nxt  = '0;
    end else if (busy_r) begin
      if ((step_r == STEP_SAT) && ge) begin
        // Quotient of 256 or more: clamp and stop early.
        quo_nxt  = BYTE_MAX;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        if (step_r != STEP_SAT) quo_nxt = {quo_r[QUO_W-2:0], ge};
        if (ge) rem_nxt = rem_r - dsh_r;
        dsh_nxt  = dsh_r >> 1;
        step_nxt = step_r - 4'd1;
        if (step_r == 4'd0) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    quo_r  <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

`ifndef SYNTHESIS
  property p_no_restart;
    @(posedge clk) disable iff (!rst_n) start |-> !busy_r;
  endproperty
  a_no_restart: assert property (p_no_restart)
    else $error("divider started while busy");

  property p_start_busy;
    @(posedge clk) disable iff (!rst_n) start |=> busy_r && !done_r;
  endproperty
  a_start_busy: assert property (p_start_busy)
    else $error("divider not busy after start");

  property p_rem_bound;
    @(posedge clk) disable iff (!rst_n)
      (busy_r && (step_r != STEP_SAT)) |-> ({1'b0, rem_r} < {dsh_r, 1'b0});
  endproperty
  a_rem_bound: assert property (p_rem_bound)
    else $error("partial remainder out of range");

  property p_done_idle;
    @(posedge clk) disable iff (!rst_n) done_r |-> !busy_r;
  endproperty
  a_done_idle: assert property (p_done_idle)
    else $error("divider done while still busy");
`endif

endmodule

// File: hw/rtl/channel_contrast_stretch.sv
// Per-channel min-max contrast stretch to 8-bit components, run as two passes
// over a frame: clear items reset every channel's running min and max, gather
// items widen the min/max of their channel, convert items return one byte,
// floor(255*(v-min)/(max-min)) clamped to 0..255, or floor(255*v/2^FRAC_BITS)
// clamped when enhancement is off or the channel is flat. Clear, gather and
// unused-mode items give no result. A convert item that goes through the
// shared restoring divider passes from acceptance through the setup steps
// S_PREP and S_NORM, the divider (its saturation test, then the quotient bits),
// a step to collect the quotient and one to load the output register. A
// quotient of 256 or more stops the divider after its saturation test. A
// convert on a bad channel goes straight to the output step; a flat channel,
// plain scaling or a non-positive numerator skips the divider. A result still
// waiting for the sink holds a finished convert in its output step. The block
// works on one item at a time; the output register lets the next item be
// accepted while a result waits for the sink. Config (enhance_enable at index
// 0, channels_in_use at index 1) must be written only while the block is idle;
// the block itself does not enforce this.
// Depends on ccs_pkg, ccs_if, ccs_stats and ccs_div.
module channel_contrast_stretch import ccs_pkg::*; #(
  parameter int MAX_CHANNELS = 4,
  parameter int FRAC_BITS    = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ccs_in_if.sink                in_if,
  ccs_out_if.source             out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [2:0] MAX_CH = 3'(MAX_CHANNELS);
  localparam int         PLAIN_W = SAMPLE_W + 7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_NORM,
    S_DIV,
    S_OUT
  } state_t;

  state_t                     state_r,  state_nxt;
  logic                       enh_r,    enh_nxt;
  logic [2:0]                 chn_r,    chn_nxt;
  logic                       oval_r,   oval_nxt;
  out_item_t                  odata_r,  odata_nxt;
  out_item_t                  res_r,    res_nxt;
  logic [1:0]                 ch_r,     ch_nxt;
  logic signed [SAMPLE_W-1:0] v_r,      v_nxt;
  logic signed [SAMPLE_W:0]   diff_r,   diff_nxt;
  logic signed [SAMPLE_W:0]   den_r,    den_nxt;
  logic                       flat_r,   flat_nxt;
  logic [QUO_W-1:0]           plain_r,  plain_nxt;

  logic                       accept;
  logic                       ch_valid;
  stats_cmd_t                 scmd;
  logic signed [SAMPLE_W-1:0] st_min, st_max;
  logic                       div_start, div_done;
  logic [NUM_W-1:0]           div_num;
  logic [DEN_W-1:0]           div_den;
  logic [QUO_W-1:0]           div_quo;
  logic signed [SAMPLE_W:0]   sdiff;
  logic signed [SAMPLE_W:0]   dmag;
  logic [PLAIN_W-1:0]         pprod, pshift;

  assign accept   = in_if.valid && in_if.ready;
  assign ch_valid = ({1'b0, in_if.data.channel} < chn_r) &&
                    ({1'b0, in_if.data.channel} < MAX_CH);

  // Min/max store commands come straight from the accepted item.
  always_comb begin
    scmd.clr = 1'b0;
    scmd.upd = 1'b0;
    scmd.ch  = (state_r == S_IDLE) ? in_if.data.channel : ch_r;
    if (accept) begin
      case (in_if.data.mode)
        MODE_CLEAR:  scmd.clr = 1'b1;
        MODE_GATHER: scmd.upd = ch_valid;
        default:     scmd.upd = 1'b0;
      endcase
    end
  end

  ccs_stats #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_stats (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (scmd),
    .upd_val (in_if.data.sample_value),
    .rd_ch   (ch_r),
    .rd_min  (st_min),
    .rd_max  (st_max)
  );

  // Plain scaling: 255*v as (v << 8) - v, then drop the fraction bits.
  assign pprod  = {v_r[SAMPLE_W-2:0], 8'b0} - {8'b0, v_r[SAMPLE_W-2:0]};
  assign pshift = pprod >> FRAC_BITS;

  // Fold the divisor sign into the numerator so the divider sees magnitudes.
  assign sdiff   = den_r[SAMPLE_W] ? -diff_r : diff_r;
  assign dmag    = den_r[SAMPLE_W] ? -den_r  : den_r;
  assign div_num = {sdiff[DEN_W-1:0], 8'b0} - {8'b0, sdiff[DEN_W-1:0]};
  assign div_den = dmag[DEN_W-1:0];

  ccs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    state_nxt = state_r;
    enh_nxt   = enh_r;
    chn_nxt   = chn_r;
    oval_nxt  = oval_r;
    odata_nxt = odata_r;
    res_nxt   = res_r;
    ch_nxt    = ch_r;
    v_nxt     = v_r;
    diff_nxt  = diff_r;
    den_nxt   = den_r;
    flat_nxt  = flat_r;
    plain_nxt = plain_r;
    div_start = 1'b0;

    // Drop the held result once the sink takes it.
    if (oval_r && out_if.ready) oval_nxt = 1'b0;

    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_ENHANCE:  enh_nxt = cfg_data[0];
        CFG_CHANNELS: chn_nxt = cfg_data;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_if.data.mode == MODE_CONVERT)) begin
          ch_nxt = in_if.data.channel;
          v_nxt  = in_if.data.sample_value;
          if (ch_valid) begin
            state_nxt = S_PREP;
          end else begin
            res_nxt   = '{pixel_byte: '0, bad_channel: 1'b1};
            state_nxt = S_OUT;
          end
        end
      end
      S_PREP: begin
        diff_nxt  = (SAMPLE_W+1)'(v_r) - (SAMPLE_W+1)'(st_min);
        den_nxt   = (SAMPLE_W+1)'(st_max) - (SAMPLE_W+1)'(st_min);
        flat_nxt  = !enh_r || (st_max == st_min);
        if (v_r[SAMPLE_W-1] || (v_r == '0)) plain_nxt = '0;
        else if (pshift > PLAIN_W'(BYTE_MAX)) plain_nxt = BYTE_MAX;
        else plain_nxt = pshift[QUO_W-1:0];
        state_nxt = S_NORM;
      end
      S_NORM: begin
        if (flat_r) begin
          res_nxt   = '{pixel_byte: plain_r, bad_channel: 1'b0};
          state_nxt = S_OUT;
        end else if (sdiff[SAMPLE_W] || (sdiff == '0)) begin
          res_nxt   = '{pixel_byte: '0, bad_channel: 1'b0};
          state_nxt = S_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_nxt   = '{pixel_byte: div_quo, bad_channel: 1'b0};
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // Hold until the output register is free, then hand the item over.
        if (!oval_r || out_if.ready) begin
          oval_nxt  = 1'b1;
          odata_nxt = res_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      enh_r   <= 1'b1;
      chn_r   <= 3'd4;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      enh_r   <= enh_nxt;
      chn_r   <= chn_nxt;
      oval_r  <= oval_nxt;
    end
    odata_r <= odata_nxt;
    res_r   <= res_nxt;
    ch_r    <= ch_nxt;
    v_r     <= v_nxt;
    diff_r  <= diff_nxt;
    den_r   <= den_nxt;
    flat_r  <= flat_nxt;
    plain_r <= plain_nxt;
  end

  assign in_if.ready  = (state_r == S_IDLE);
  assign out_if.valid = oval_r;
  assign out_if.data  = odata_r;

`ifndef SYNTHESIS
  property p_bad_zero;
    @(posedge clk) disable iff (!rst_n)
      (out_if.valid && out_if.data.bad_channel) |-> (out_if.data.pixel_byte == '0);
  endproperty
  a_bad_zero: assert property (p_bad_zero)
    else $error("bad channel item with nonzero byte");

  property p_bad_shortcut;
    @(posedge clk) disable iff (!rst_n)
      (accept && (in_if.data.mode == MODE_CONVERT) && !ch_valid) |=> (state_r == S_OUT);
  endproperty
  a_bad_shortcut: assert property (p_bad_shortcut)
    else $error("bad channel convert did not go straight to output");

  property p_div_from_norm;
    @(posedge clk) disable iff (!rst_n) div_start |-> (state_r == S_NORM) && !flat_r;
  endproperty
  a_div_from_norm: assert property (p_div_from_norm)
    else $error("divider started outside the setup step");

  property p_div_nonzero;
    @(posedge clk) disable iff (!rst_n) div_start |-> (div_den != '0);
  endproperty
  a_div_nonzero: assert property (p_div_nonzero)
    else $error("divider started with a zero range");
`endif

endmodule

// File: bench/ccs_checker.sv
`timescale 1ns / 100ps
// Result checker for channel_contrast_stretch: keeps its own copy of the per-channel
// min/max statistics and of both registers, and predicts each converted byte.
// Depends on ccs_pkg for the item, mode and register types.
module ccs_checker import ccs_pkg::*; #(
  parameter int MAX_CHANNELS = 4,
  parameter int FRAC_BITS    = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    bytes_pending,
  output int                    bytes_checked
);

  typedef struct {
    in_item_t  item;
    out_item_t res;
  } pending_byte_t;

  localparam int PRINT_CAP = 100;

  logic signed [SAMPLE_W-1:0] run_min [MAX_CHANNELS];
  logic signed [SAMPLE_W-1:0] run_max [MAX_CHANNELS];
  logic                       stretch_on;
  logic [CFG_DATA_W-1:0]      chans_in_use;
  pending_byte_t              byte_queue [$];
  int                         n_fail = 0;
  int                         n_checked = 0;

  task automatic report_mismatch(input string msg);
    if (n_fail < PRINT_CAP)
      $display("[%0t] mismatch: %s", $realtime, msg);
    n_fail++;
  endtask

  function automatic logic [QUO_W-1:0] clamp_byte(input longint q);
    if (q <= 0)
      return '0;
    if (q > 255)
      return BYTE_MAX;
    return q[QUO_W-1:0];
  endfunction

  // Plain scaling: floor(255 * v / 2^FRAC_BITS), clamped.
  function automatic logic [QUO_W-1:0] scaled_byte(input logic signed [SAMPLE_W-1:0] v);
    return clamp_byte((longint'(v) * 255) >>> FRAC_BITS);
  endfunction

  // Stretch by the channel range; an empty channel has a negative range.
  function automatic logic [QUO_W-1:0] stretched_byte(
    input logic signed [SAMPLE_W-1:0] v,
    input logic signed [SAMPLE_W-1:0] lo,
    input logic signed [SAMPLE_W-1:0] hi
  );
    longint num;
    longint den;
    num = (longint'(v) - longint'(lo)) * 255;
    den = longint'(hi) - longint'(lo);
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (num <= 0)
      return '0;
    return clamp_byte(num / den);
  endfunction

  function automatic bit channel_ok(input logic [1:0] ch);
    return (ch < chans_in_use) && (ch < MAX_CHANNELS);
  endfunction

  function automatic out_item_t converted_byte(input in_item_t item);
    out_item_t r;
    int        ch;
    ch = item.channel;
    r  = '0;
    if (!channel_ok(item.channel))
      r.bad_channel = 1'b1;
    else if (stretch_on && run_max[ch] != run_min[ch])
      r.pixel_byte = stretched_byte(item.sample_value, run_min[ch], run_max[ch]);
    else
      r.pixel_byte = scaled_byte(item.sample_value);
    return r;
  endfunction

  task automatic clear_stats();
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      run_min[i] = STAT_MIN_RST;
      run_max[i] = STAT_MAX_RST;
    end
  endtask

  always @(posedge clk) begin
    pending_byte_t want;
    int            ch;
    if (!rst_n) begin
      clear_stats();
      stretch_on   = 1'b1;
      chans_in_use = 3'd4;
      byte_queue.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENHANCE:  stretch_on   = cfg_data[0];
          CFG_CHANNELS: chans_in_use = cfg_data;
          default: ;
        endcase
      end
      // Results first: a result can never belong to an item accepted at this edge.
      if (out_valid && out_ready) begin
        if (byte_queue.size() == 0) begin
          report_mismatch($sformatf("result byte %0d bad %0b with no convert waiting",
                                    out_data.pixel_byte, out_data.bad_channel));
        end else begin
          want = byte_queue.pop_front();
          n_checked++;
          if (out_data.pixel_byte !== want.res.pixel_byte)
            report_mismatch($sformatf("ch %0d v %0d: pixel_byte %0d, predicted %0d",
                                      want.item.channel, want.item.sample_value,
                                      out_data.pixel_byte, want.res.pixel_byte));
          if (out_data.bad_channel !== want.res.bad_channel)
            report_mismatch($sformatf("ch %0d v %0d: bad_channel %0b, predicted %0b",
                                      want.item.channel, want.item.sample_value,
                                      out_data.bad_channel, want.res.bad_channel));
        end
      end
      if (in_valid && in_ready) begin
        ch = in_data.channel;
        case (in_data.mode)
          MODE_CLEAR:  clear_stats();
          MODE_GATHER: begin
            if (channel_ok(in_data.channel)) begin
              if (in_data.sample_value < run_min[ch])
                run_min[ch] = in_data.sample_value;
              if (in_data.sample_value > run_max[ch])
                run_max[ch] = in_data.sample_value;
            end
          end
          MODE_CONVERT: begin
            want.item = in_data;
            want.res  = converted_byte(in_data);
            byte_queue.push_back(want);
          end
          default: ;
        endcase
      end
    end
    fail_count    <= n_fail;
    bytes_pending <= byte_queue.size();
    bytes_checked <= n_checked;
  end

endmodule

// File: bench/channel_contrast_stretch_tb.sv
`timescale 1ns / 100ps
// Top of the channel_contrast_stretch bench: clock, reset, stimulus and verdict.
// Depends on ccs_pkg, the ccs_if interfaces, the block itself and ccs_checker.
module channel_contrast_stretch_tb;
  import ccs_pkg::*;

  // Mode code 3 is unused by the block; items carrying it must be ignored.
  localparam logic [1:0] MODE_SPARE   = 2'd3;
  // Hold this long after the last byte before touching the registers.
  localparam int         HOLD_CYCLES  = 24;
  localparam int         ITEM_TARGET  = 1150;

  logic                  clk   = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ccs_in_if  in_ch ();
  ccs_out_if out_ch ();

  bit quiet;        // when set, neither side idles
  int items_sent;
  int settings_run;
  int chans_now;    // mirror of channels_in_use, for building frames
  int fail_count;
  int bytes_pending;
  int bytes_checked;

  always #6 clk = ~clk;

  channel_contrast_stretch #(
    .MAX_CHANNELS (4),
    .FRAC_BITS    (12)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ccs_checker #(
    .MAX_CHANNELS (4),
    .FRAC_BITS    (12)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_data       (in_ch.data),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_data      (out_ch.data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .bytes_pending (bytes_pending),
    .bytes_checked (bytes_checked)
  );

  // Result side: ready drops at random, never during a quiet stretch.
  always @(posedge clk) begin
    out_ch.ready <= rst_n && (quiet || $urandom_range(99) >= 17);
  end

  // Hard limit on the run: far beyond the slowest correct run.
  initial begin
    #6_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic in_item_t make_item(input logic [1:0] mode, input int ch, input int v);
    in_item_t item;
    if (v > 32767)
      v = 32767;
    if (v < -32768)
      v = -32768;
    item.mode         = mode;
    item.channel      = ch[1:0];
    item.sample_value = v[SAMPLE_W-1:0];
    return item;
  endfunction

  // Any 16-bit pattern, so every sample bit sees both values.
  function automatic int any_sample();
    return int'($urandom_range(65535)) - 32768;
  endfunction

  // Present one item, idling first at random; leave valid high on return so a
  // back-to-back item needs no second assignment in the same step.
  task automatic send_item(input in_item_t item);
    while (!quiet && $urandom_range(99) < 17) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    @(posedge clk);
    while (!in_ch.ready)
      @(posedge clk);
    items_sent++;
  endtask

  // Drop valid, let every expected byte come back, then let the block settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (bytes_pending != 0)
      @(posedge clk);
    repeat (HOLD_CYCLES) @(posedge clk);
  endtask

  // Leave the write enable high on return; the caller drops it after its last write.
  task automatic write_reg(input cfg_reg_t idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  // Move to a new register setting; enhance gets random upper data bits,
  // which the block must ignore.
  task automatic set_regs(input bit enhance, input int chans);
    drain();
    write_reg(CFG_ENHANCE, int'({2'($urandom_range(3)), enhance}));
    write_reg(CFG_CHANNELS, chans);
    cfg_we    <= 1'b0;
    chans_now = chans;
    settings_run++;
  endtask

  // Occasional garbage: any mode including the spare one, any channel, any value.
  task automatic maybe_noise();
    if ($urandom_range(99) < 12)
      send_item(make_item(2'($urandom_range(3)), $urandom_range(3), any_sample()));
  endtask

  function automatic int near_value(input int center, input int spread);
    if ($urandom_range(19) == 0)
      return any_sample();
    return center + int'($urandom_range(2 * spread)) - spread;
  endfunction

  // One frame: a clear (mostly), gather over the channels in use, then convert them.
  task automatic run_frame();
    int nch;
    int center;
    int spread;
    int n_gather;
    int n_convert;
    nch = (chans_now < 1) ? 1 : (chans_now > 4 ? 4 : chans_now);
    center = any_sample();
    case ($urandom_range(3))
      0:       spread = $urandom_range(16);
      1:       spread = $urandom_range(600);
      2:       spread = $urandom_range(8000);
      default: spread = 40000;
    endcase
    n_gather  = $urandom_range(2, 12);
    n_convert = $urandom_range(4, 16);
    // Skip the clear now and then so statistics carry over between frames.
    if ($urandom_range(9) != 0)
      send_item(make_item(MODE_CLEAR, $urandom_range(3), any_sample()));
    for (int k = 0; k < n_gather; k++) begin
      maybe_noise();
      send_item(make_item(MODE_GATHER, k % nch, near_value(center, spread)));
    end
    for (int k = 0; k < n_convert; k++) begin
      maybe_noise();
      // Reach past the gathered range to hit both clamps.
      send_item(make_item(MODE_CONVERT, k % nch, near_value(center, spread + spread / 4)));
    end
  endtask

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_ENHANCE;
    cfg_data     = '0;
    quiet        = 1'b0;
    items_sent   = 0;
    settings_run = 1;
    chans_now    = 4;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset setting: stretch on, four channels.
    send_item(make_item(MODE_CLEAR, 0, 0));
    send_item(make_item(MODE_GATHER, 0, -32768));   // channel 0 spans the full range
    send_item(make_item(MODE_GATHER, 0, 32767));
    send_item(make_item(MODE_GATHER, 1, 0));
    send_item(make_item(MODE_GATHER, 1, 100));
    send_item(make_item(MODE_GATHER, 2, 4096));     // channel 2 stays flat
    send_item(make_item(MODE_SPARE, 0, -1));        // ignored, no result
    send_item(make_item(MODE_CONVERT, 0, -32768));
    send_item(make_item(MODE_CONVERT, 0, 32767));
    send_item(make_item(MODE_CONVERT, 0, 0));
    send_item(make_item(MODE_CONVERT, 1, 50));
    send_item(make_item(MODE_CONVERT, 1, -1));      // below min: clamps low
    send_item(make_item(MODE_CONVERT, 1, 200));     // above max: clamps high
    send_item(make_item(MODE_CONVERT, 2, 4096));    // flat: plain scaling
    send_item(make_item(MODE_CONVERT, 2, 100));
    send_item(make_item(MODE_CONVERT, 3, 0));       // nothing gathered: negative range
    send_item(make_item(MODE_CONVERT, 3, -32768));

    // Fewer channels: 2 and 3 become bad, and gather on them is ignored.
    set_regs(1'b1, 2);
    send_item(make_item(MODE_GATHER, 3, 1000));
    send_item(make_item(MODE_CONVERT, 2, 100));
    send_item(make_item(MODE_CONVERT, 3, 32767));
    send_item(make_item(MODE_CONVERT, 1, 50));
    // No channels at all: everything is bad.
    set_regs(1'b1, 0);
    send_item(make_item(MODE_CONVERT, 0, 4096));
    // Counts above the channel limit act as the limit.
    set_regs(1'b1, 7);
    send_item(make_item(MODE_CONVERT, 3, 0));
    // Stretch off: plain scaling even where a range exists.
    set_regs(1'b0, 4);
    send_item(make_item(MODE_CONVERT, 1, 50));
    send_item(make_item(MODE_CONVERT, 0, -5));
    send_item(make_item(MODE_CONVERT, 0, 32767));

    // Random part: well-formed frames with noise, over a spread of settings.
    for (int phase = 0; phase < 8; phase++) begin
      int stop_at;
      case (phase)
        0: set_regs(1'b1, 4);
        1: set_regs(1'b1, 1);
        2: set_regs(1'b0, 4);
        3: set_regs(1'b1, 3);
        4: set_regs(1'b1, 7);
        5: set_regs(1'b0, 0);
        6: set_regs(1'b1, 2);
        default: set_regs(1'b0, 5);
      endcase
      // One setting runs without any idling on either side.
      quiet   = (phase == 3);
      stop_at = items_sent + (ITEM_TARGET - items_sent) / (8 - phase);
      while (items_sent < stop_at)
        run_frame();
    end
    quiet = 1'b0;

    drain();
    $display("Ran %0d items over %0d register settings, %0d converted bytes compared.",
             items_sent, settings_run, bytes_checked);
    if (fail_count == 0 && bytes_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
